// ===== rtl/segment_box_intersect_test_core_defines.svh =====
// ----------------------------------------------------------------------------
// Segment/box intersect test: assertion macros
// Shared property forms for the checker of the segment/box test core.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_INTERSECT_TEST_CORE_DEFINES_SVH
`define SEGMENT_BOX_INTERSECT_TEST_CORE_DEFINES_SVH

// antecedent implies consequent (may be a delayed sequence), masked in reset
`define SBIT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("sbit: implication check failed");

// antecedent implies consequent on the next edge, checked in reset too
`define SBIT_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sbit: next-cycle check failed");

`endif

// ===== rtl/sbit_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment/box intersect test: package
// Widths, payload types and inter-stage structs shared by the core.
// ----------------------------------------------------------------------------
package sbit_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int FRAC_BITS_MAX = 24;
   localparam int COORD_W       = 32;
   localparam int BOX_W         = 16;
   localparam int SUM_W         = BOX_W + 1;
   localparam int DIFF_W        = COORD_W + 1;
   localparam int WIDE_W        = SUM_W + FRAC_BITS_MAX + 1;
   localparam int MAG_W         = COORD_W;
   localparam int PROD_W        = 2 * MAG_W;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = BOX_W;
   localparam int LATENCY       = 7;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [BOX_W-1:0]   box_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic [MAG_W-1:0]          mag_type;
   typedef logic [PROD_W-1:0]         prod_type;

   localparam wide_type WIDE_ZERO = '0;
   localparam wide_type WIDE_ONE  = wide_type'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = CSR_IDX_W'(0),
      CSR_CENTER_Y = CSR_IDX_W'(1)
   } csr_index_type;

   // front end -> multiplier stage
   typedef struct packed {
      logic    xhit_ok;
      logic    vert;
      logic    vhit;
      logic    neg;
      mag_type adx;
      mag_type ady;
      mag_type aox_a;
      mag_type aox_b;
      mag_type tg_val;
      mag_type tl_val;
      logic    tg_le0;
      logic    tg_gt;
      logic    tl_le0;
      logic    tl_gt;
   } sbit_mid_type;

   // multiplier stage -> decision stages
   typedef struct packed {
      logic     xhit_ok;
      logic     vert;
      logic     vhit;
      logic     neg;
      mag_type  half;
      prod_type n_a;
      prod_type n_b;
      prod_type p_g;
      prod_type p_l;
      logic     tg_le0;
      logic     tg_gt;
      logic     tl_le0;
      logic     tl_gt;
   } sbit_prod_type;

endpackage

// ===== rtl/sbit_front.sv =====
// ----------------------------------------------------------------------------
// Segment/box intersect test: front end
// Stages 1-4: corner offset and scaling, x clipping, slope magnitudes and
// y thresholds reduced to integer compare limits.
// ----------------------------------------------------------------------------
module sbit_front import sbit_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  coord_type    seg_x0,
   input  coord_type    seg_y0,
   input  coord_type    seg_x1,
   input  coord_type    seg_y1,
   input  box_type      box_left,
   input  box_type      box_bottom,
   input  box_type      box_right,
   input  box_type      box_top,
   input  box_type      center_x,
   input  box_type      center_y,
   output logic         mid_valid,
   output sbit_mid_type mid
);

   typedef struct packed {
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
      sum_type   bl;
      sum_type   bb;
      sum_type   br;
      sum_type   bt;
   } st1_type;

   typedef struct packed {
      coord_type x0;
      coord_type minx;
      coord_type maxx;
      sum_type   bl;
      sum_type   br;
      diff_type  dx;
      diff_type  dy;
      wide_type  kb;
      wide_type  kt;
      logic      box_ok;
      logic      vhit;
   } st2_type;

   typedef struct packed {
      coord_type x0;
      wide_type  lox;
      wide_type  hix;
      wide_type  tg;
      wide_type  tl;
      mag_type   adx;
      mag_type   ady;
      logic      sdx;
      logic      neg;
      logic      vert;
      logic      box_ok;
      logic      vhit;
   } st3_type;

   function automatic sum_type add_center(input box_type b, input box_type c);
      return sum_type'({b[BOX_W-1], b}) + sum_type'({c[BOX_W-1], c});
   endfunction

   function automatic wide_type scale(input sum_type s);
      wide_type w;
      w = {{(WIDE_W-SUM_W){s[SUM_W-1]}}, s};
      return w <<< FRAC_BITS;
   endfunction

   function automatic wide_type widen(input coord_type c);
      return {{(WIDE_W-COORD_W){c[COORD_W-1]}}, c};
   endfunction

   function automatic diff_type sub_coord(input coord_type a, input coord_type b);
      return diff_type'({a[COORD_W-1], a}) - diff_type'({b[COORD_W-1], b});
   endfunction

   function automatic mag_type mag_of(input diff_type d);
      diff_type n;
      n = d[DIFF_W-1] ? -d : d;
      return n[MAG_W-1:0];
   endfunction

   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   st1_type      st1_in, st1_ff;
   st2_type      st2_in, st2_ff;
   st3_type      st3_in, st3_ff;
   sbit_mid_type mid_in, mid_ff;

   wide_type y0w, y1w, bbw, btw;
   wide_type blw, brw, mnw, mxw;
   wide_type x0w, da, db, adyw;

   // stage 1: capture, box corners moved by the grid center
   always_comb begin
      st1_in.x0 = seg_x0;
      st1_in.y0 = seg_y0;
      st1_in.x1 = seg_x1;
      st1_in.y1 = seg_y1;
      st1_in.bl = add_center(box_left, center_x);
      st1_in.br = add_center(box_right, center_x);
      st1_in.bb = add_center(box_bottom, center_y);
      st1_in.bt = add_center(box_top, center_y);
   end

   // stage 2: x extent, deltas, y offsets to the box edges
   always_comb begin
      y0w = widen(st1_ff.y0);
      y1w = widen(st1_ff.y1);
      bbw = scale(st1_ff.bb);
      btw = scale(st1_ff.bt);
      st2_in.x0     = st1_ff.x0;
      st2_in.minx   = (st1_ff.x0 < st1_ff.x1) ? st1_ff.x0 : st1_ff.x1;
      st2_in.maxx   = (st1_ff.x0 < st1_ff.x1) ? st1_ff.x1 : st1_ff.x0;
      st2_in.bl     = st1_ff.bl;
      st2_in.br     = st1_ff.br;
      st2_in.dx     = sub_coord(st1_ff.x1, st1_ff.x0);
      st2_in.dy     = sub_coord(st1_ff.y1, st1_ff.y0);
      st2_in.kb     = bbw - y0w;
      st2_in.kt     = btw - y0w;
      st2_in.box_ok = st1_ff.bb <= st1_ff.bt;
      st2_in.vhit   = ((y0w >= bbw) | (y1w >= bbw)) & ((y0w <= btw) | (y1w <= btw));
   end

   // stage 3: clip to box, magnitudes, quotient thresholds
   always_comb begin
      blw = scale(st2_ff.bl);
      brw = scale(st2_ff.br);
      mnw = widen(st2_ff.minx);
      mxw = widen(st2_ff.maxx);
      st3_in.x0     = st2_ff.x0;
      st3_in.lox    = (mnw < blw) ? blw : mnw;
      st3_in.hix    = (mxw > brw) ? brw : mxw;
      st3_in.adx    = mag_of(st2_ff.dx);
      st3_in.ady    = mag_of(st2_ff.dy);
      st3_in.sdx    = st2_ff.dx[DIFF_W-1];
      st3_in.neg    = st2_ff.dy[DIFF_W-1];
      st3_in.vert   = st2_ff.dx == diff_type'(0);
      st3_in.box_ok = st2_ff.box_ok;
      st3_in.vhit   = st2_ff.vhit;
      // y >= bottom and y <= top become q >= T tests, inverted when dy < 0
      st3_in.tg     = st2_ff.dy[DIFF_W-1] ? (WIDE_ONE - st2_ff.kb) : st2_ff.kb;
      st3_in.tl     = st2_ff.dy[DIFF_W-1] ? (WIDE_ZERO - st2_ff.kt) : (st2_ff.kt + WIDE_ONE);
   end

   // stage 4: x overlap, |x - x0| at both clipped bounds, threshold range
   always_comb begin
      x0w  = widen(st3_ff.x0);
      da   = st3_ff.sdx ? (x0w - st3_ff.lox) : (st3_ff.lox - x0w);
      db   = st3_ff.sdx ? (x0w - st3_ff.hix) : (st3_ff.hix - x0w);
      adyw = {{(WIDE_W-MAG_W){1'b0}}, st3_ff.ady};
      mid_in.xhit_ok = (st3_ff.lox <= st3_ff.hix) & st3_ff.box_ok;
      mid_in.vert    = st3_ff.vert;
      mid_in.vhit    = st3_ff.vhit;
      mid_in.neg     = st3_ff.neg;
      mid_in.adx     = st3_ff.adx;
      mid_in.ady     = st3_ff.ady;
      mid_in.aox_a   = da[MAG_W-1:0];
      mid_in.aox_b   = db[MAG_W-1:0];
      mid_in.tg_val  = st3_ff.tg[MAG_W-1:0];
      mid_in.tl_val  = st3_ff.tl[MAG_W-1:0];
      mid_in.tg_le0  = st3_ff.tg <= WIDE_ZERO;
      mid_in.tg_gt   = st3_ff.tg > adyw;
      mid_in.tl_le0  = st3_ff.tl <= WIDE_ZERO;
      mid_in.tl_gt   = st3_ff.tl > adyw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      st1_ff <= st1_in;
      st2_ff <= st2_in;
      st3_ff <= st3_in;
      mid_ff <= mid_in;
   end

   assign mid_valid = v4_ff;
   assign mid       = mid_ff;

endmodule

// ===== rtl/sbit_mul.sv =====
// ----------------------------------------------------------------------------
// Segment/box intersect test: multiplier stage
// Stage 5: interpolation numerators and threshold products, 32x32 each.
// ----------------------------------------------------------------------------
module sbit_mul import sbit_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          mid_valid,
   input  sbit_mid_type  mid,
   output logic          prod_valid,
   output sbit_prod_type prod
);

   logic          v5_ff;
   sbit_prod_type prod_in, prod_ff;

   always_comb begin
      prod_in.xhit_ok = mid.xhit_ok;
      prod_in.vert    = mid.vert;
      prod_in.vhit    = mid.vhit;
      prod_in.neg     = mid.neg;
      prod_in.half    = mid.adx >> 1;
      prod_in.n_a     = PROD_W'(mid.ady) * PROD_W'(mid.aox_a);
      prod_in.n_b     = PROD_W'(mid.ady) * PROD_W'(mid.aox_b);
      prod_in.p_g     = PROD_W'(mid.tg_val) * PROD_W'(mid.adx);
      prod_in.p_l     = PROD_W'(mid.tl_val) * PROD_W'(mid.adx);
      prod_in.tg_le0  = mid.tg_le0;
      prod_in.tg_gt   = mid.tg_gt;
      prod_in.tl_le0  = mid.tl_le0;
      prod_in.tl_gt   = mid.tl_gt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod_valid = v5_ff;
   assign prod       = prod_ff;

endmodule

// ===== rtl/sbit_judge.sv =====
// ----------------------------------------------------------------------------
// Segment/box intersect test: decision stages
// Stages 6-7: rounded quotient compares against the y thresholds, final hit.
// ----------------------------------------------------------------------------
module sbit_judge import sbit_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          prod_valid,
   input  sbit_prod_type prod,
   output logic          out_valid,
   output logic          out_hit
);

   logic     v6_ff, v7_ff;
   logic     yhit_in, yhit_ff;
   logic     vhit_ff, vert_ff, xhit_ok_ff;
   logic     hit_in, hit_ff;
   prod_type aa, ab;
   logic     ga, gb, la, lb;

   // q >= T  <=>  N + |dx|/2 >= T*|dx|, for T in 1..|dy|
   always_comb begin
      aa = prod.n_a + PROD_W'(prod.half);
      ab = prod.n_b + PROD_W'(prod.half);
      ga = prod.tg_le0 | (~prod.tg_gt & (aa >= prod.p_g));
      gb = prod.tg_le0 | (~prod.tg_gt & (ab >= prod.p_g));
      la = prod.tl_le0 | (~prod.tl_gt & (aa >= prod.p_l));
      lb = prod.tl_le0 | (~prod.tl_gt & (ab >= prod.p_l));
      yhit_in = ((ga ^ prod.neg) | (gb ^ prod.neg)) &
                ((la ^ ~prod.neg) | (lb ^ ~prod.neg));
   end

   assign hit_in = xhit_ok_ff & (vert_ff ? vhit_ff : yhit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v6_ff <= prod_valid;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      yhit_ff    <= yhit_in;
      vhit_ff    <= prod.vhit;
      vert_ff    <= prod.vert;
      xhit_ok_ff <= prod.xhit_ok;
      hit_ff     <= hit_in;
   end

   assign out_valid = v7_ff;
   assign out_hit   = hit_ff;

endmodule

// ===== rtl/segment_box_intersect_test_core.sv =====
// ----------------------------------------------------------------------------
// Segment/box intersect test core
// Tests a fixed-point line segment against an integer grid cell rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   Command: drive req_* and raise start; a beat is taken at each rising
//   edge with start high and busy low. busy is high only during reset, so a
//   new command can be taken every cycle.
//   Result: rsp_valid is high for one cycle with rsp_hit; one result per
//   command, in command order. The receiver cannot stall; nothing buffers.
//   Pipeline: seven register stages. Throughput: one per cycle, set by the
//   fully pipelined 32x32 multiplier stage.
//   Config: csr_valid/csr_ready write center_x (index 0) or center_y
//   (index 1); other indexes are dropped. Write only while no command is in
//   flight. csr_ready is low during reset.
//   Reset: synchronous; clears the pipeline valid bits and both centers.
// ----------------------------------------------------------------------------
module segment_box_intersect_test_core import sbit_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  coord_type             req_seg_x0,
   input  coord_type             req_seg_y0,
   input  coord_type             req_seg_x1,
   input  coord_type             req_seg_y1,
   input  box_type               req_box_left,
   input  box_type               req_box_bottom,
   input  box_type               req_box_right,
   input  box_type               req_box_top,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   box_type       cx_in, cx_ff, cy_in, cy_ff;
   logic          accept;
   logic          mid_valid, prod_valid;
   sbit_mid_type  mid;
   sbit_prod_type prod;

   assign busy      = reset;
   assign csr_ready = ~reset;
   assign accept    = start & ~busy;

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CENTER_X: cx_in = box_type'(csr_data);
            CSR_CENTER_Y: cy_in = box_type'(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
      end else begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
   end

   sbit_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .seg_x0     (req_seg_x0),
      .seg_y0     (req_seg_y0),
      .seg_x1     (req_seg_x1),
      .seg_y1     (req_seg_y1),
      .box_left   (req_box_left),
      .box_bottom (req_box_bottom),
      .box_right  (req_box_right),
      .box_top    (req_box_top),
      .center_x   (cx_ff),
      .center_y   (cy_ff),
      .mid_valid  (mid_valid),
      .mid        (mid)
   );

   sbit_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .mid_valid  (mid_valid),
      .mid        (mid),
      .prod_valid (prod_valid),
      .prod       (prod)
   );

   sbit_judge u_judge (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod       (prod),
      .out_valid  (rsp_valid),
      .out_hit    (rsp_hit)
   );

endmodule

// ===== rtl/sbit_checker.sv =====
// ----------------------------------------------------------------------------
// Segment/box intersect test: port checker
// Latency, inverted-box and reset-flush checks, bound to the core.
// ----------------------------------------------------------------------------
`include "segment_box_intersect_test_core_defines.svh"

module sbit_checker import sbit_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input box_type req_box_left,
   input box_type req_box_bottom,
   input box_type req_box_right,
   input box_type req_box_top,
   input logic    rsp_valid,
   input logic    rsp_hit
);

   `SBIT_ASSERT_IMPLY(a_latency, clock, reset, start && !busy, ##(LATENCY) rsp_valid)
   `SBIT_ASSERT_IMPLY(a_x_inverted, clock, reset, start && !busy && (req_box_left > req_box_right), ##(LATENCY) (rsp_valid && !rsp_hit))
   `SBIT_ASSERT_IMPLY(a_y_inverted, clock, reset, start && !busy && (req_box_bottom > req_box_top), ##(LATENCY) (rsp_valid && !rsp_hit))
   `SBIT_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid)

endmodule

bind segment_box_intersect_test_core sbit_checker u_sbit_checker (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Segment/box intersect test core: testbench
// Sends fixed-point segments and grid cell rectangles to the core and checks
// every hit flag against a predictor of the clip and interpolate test. The
// run covers directed edge cases and then several center settings with
// random traffic. Command gaps are random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sbit_pkg::*;

   localparam int     CLK_HALF    = 10;
   localparam int     RESET_CYC   = 10;
   localparam int     GAP_MAX     = 18;
   localparam int     PHASES      = 6;
   localparam int     PHASE_CMDS  = 317;
   localparam longint CYCLE_LIMIT = 400000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_3 = CSR_IDX_W'(3);

   localparam coord_type FX_ONE  = 32'sh0001_0000;
   localparam coord_type FX_LSB  = 32'sh0000_0001;
   localparam coord_type FX_HALF = 32'sh0000_8000;
   localparam coord_type FX_MAX  = 32'sh7fff_ffff;
   localparam coord_type FX_MIN  = 32'sh8000_0000;
   localparam box_type   BOX_MAX = 16'sh7fff;
   localparam box_type   BOX_MIN = 16'sh8000;

   typedef struct {
      coord_type seg_x0;
      coord_type seg_y0;
      coord_type seg_x1;
      coord_type seg_y1;
      box_type   box_left;
      box_type   box_bottom;
      box_type   box_right;
      box_type   box_top;
   } seg_box_cmd_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic                  busy;
   coord_type             req_seg_x0     = '0;
   coord_type             req_seg_y0     = '0;
   coord_type             req_seg_x1     = '0;
   coord_type             req_seg_y1     = '0;
   box_type               req_box_left   = '0;
   box_type               req_box_bottom = '0;
   box_type               req_box_right  = '0;
   box_type               req_box_top    = '0;
   logic                  rsp_valid;
   logic                  rsp_hit;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_data       = '0;

   box_type center_x_model = '0;
   box_type center_y_model = '0;
   bit      pending_hits[$];
   bit      no_idle_run    = 1'b0;
   int      cmds_issued    = 0;
   int      results_checked = 0;
   int      hits_seen      = 0;
   int      csr_writes     = 0;
   int      center_settings = 1;
   int      error_count    = 0;
   longint  cycle_count    = 0;

   segment_box_intersect_test_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_seg_x0     (req_seg_x0),
      .req_seg_y0     (req_seg_y0),
      .req_seg_x1     (req_seg_x1),
      .req_seg_y1     (req_seg_y1),
      .req_box_left   (req_box_left),
      .req_box_bottom (req_box_bottom),
      .req_box_right  (req_box_right),
      .req_box_top    (req_box_top),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_hits.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---- predictor ----------------------------------------------------------
   function automatic bit [63:0] magnitude(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // y on the segment's line at x, rounded to nearest, ties away from y0
   function automatic longint interp_y(input longint x0, y0, x1, y1, x);
      longint    dx, dy, ox;
      bit [63:0] adx, q;
      bit        neg;
      dx  = x1 - x0;
      dy  = y1 - y0;
      ox  = x - x0;
      adx = magnitude(dx);
      q   = (magnitude(dy) * magnitude(ox) + (adx >> 1)) / adx;
      neg = ((dy < 0) != (ox < 0)) != (dx < 0);
      if (q == 0)
         return y0;
      return neg ? y0 - $signed(q) : y0 + $signed(q);
   endfunction

   function automatic bit segment_hits_box(input seg_box_cmd_type c);
      longint x0, y0, x1, y1, bl, bb, br, bt, lox, hix, loy, hiy, t, unit;
      unit = longint'(1) <<< FRAC_BITS_DEF;
      x0   = longint'(c.seg_x0);
      y0   = longint'(c.seg_y0);
      x1   = longint'(c.seg_x1);
      y1   = longint'(c.seg_y1);
      bl   = (longint'(c.box_left) + longint'(center_x_model)) * unit;
      br   = (longint'(c.box_right) + longint'(center_x_model)) * unit;
      bb   = (longint'(c.box_bottom) + longint'(center_y_model)) * unit;
      bt   = (longint'(c.box_top) + longint'(center_y_model)) * unit;
      lox  = (x0 < x1) ? x0 : x1;
      hix  = (x0 < x1) ? x1 : x0;
      if (hix > br)
         hix = br;
      if (lox < bl)
         lox = bl;
      if (lox > hix)
         return 1'b0;
      if (x1 != x0) begin
         loy = interp_y(x0, y0, x1, y1, lox);
         hiy = interp_y(x0, y0, x1, y1, hix);
      end else begin
         loy = y0;
         hiy = y1;
      end
      if (loy > hiy) begin
         t   = loy;
         loy = hiy;
         hiy = t;
      end
      if (hiy > bt)
         hiy = bt;
      if (loy < bb)
         loy = bb;
      return loy <= hiy;
   endfunction

   function automatic void queue_expected(input bit want);
      pending_hits = {pending_hits, want};
   endfunction

   // ---- result check -------------------------------------------------------
   always @(posedge clock) begin
      bit hit_want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_hits.size() == 0) begin
            error_count++;
            $error("rsp_hit: unexpected result beat, expected none, actual %0b", rsp_hit);
         end else begin
            hit_want = pending_hits.pop_front();
            results_checked++;
            if (rsp_hit === 1'b1)
               hits_seen++;
            if (rsp_hit !== hit_want) begin
               error_count++;
               $error("rsp_hit mismatch: expected %0b, actual %0b", hit_want, rsp_hit);
            end
         end
      end
   end

   // ---- drivers ------------------------------------------------------------
   // Called at a rising edge; leaves start high so that back-to-back beats run
   // without a gap.
   task automatic send_cmd(input seg_box_cmd_type c);
      int gap;
      gap = no_idle_run ? 0 : $urandom_range(0, GAP_MAX);
      if ($urandom_range(0, 39) == 0)
         no_idle_run = !no_idle_run;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_seg_x0     <= c.seg_x0;
      req_seg_y0     <= c.seg_y0;
      req_seg_x1     <= c.seg_x1;
      req_seg_y1     <= c.seg_y1;
      req_box_left   <= c.box_left;
      req_box_bottom <= c.box_bottom;
      req_box_right  <= c.box_right;
      req_box_top    <= c.box_top;
      do @(posedge clock); while (busy !== 1'b0);
      queue_expected(segment_hits_box(c));
      cmds_issued++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_hits.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input box_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_CENTER_X)
         center_x_model = value;
      else if (idx == CSR_CENTER_Y)
         center_y_model = value;
      csr_writes++;
   endtask

   // spare index write in the middle must leave both centers alone
   task automatic set_centers(input box_type cx, input box_type cy);
      wait_drained();
      write_csr(CSR_CENTER_X, cx);
      write_csr($urandom_range(0, 1) ? CSR_UNUSED_2 : CSR_UNUSED_3,
                box_type'($urandom_range(0, 65535)));
      write_csr(CSR_CENTER_Y, cy);
      csr_valid <= 1'b0;
      center_settings++;
   endtask

   // ---- stimulus helpers ---------------------------------------------------
   function automatic seg_box_cmd_type make_cmd(input coord_type x0, y0, x1, y1,
                                                input box_type l, b, r, t);
      seg_box_cmd_type c;
      c.seg_x0     = x0;
      c.seg_y0     = y0;
      c.seg_x1     = x1;
      c.seg_y1     = y1;
      c.box_left   = l;
      c.box_bottom = b;
      c.box_right  = r;
      c.box_top    = t;
      return c;
   endfunction

   function automatic longint pick(input longint lo, hi);
      return lo + longint'($urandom_range(0, 32'(hi - lo)));
   endfunction

   function automatic box_type clamp16(input longint v);
      if (v > BOX_MAX)
         return BOX_MAX;
      if (v < BOX_MIN)
         return BOX_MIN;
      return box_type'(v);
   endfunction

   function automatic coord_type clamp32(input longint v);
      if (v > FX_MAX)
         return FX_MAX;
      if (v < FX_MIN)
         return FX_MIN;
      return coord_type'(v);
   endfunction

   // endpoint near an integer span, often exactly on a grid line
   function automatic coord_type near_coord(input longint lo, hi);
      longint frac;
      frac = ($urandom_range(0, 2) == 0) ? 0 : pick(0, (1 << FRAC_BITS_DEF) - 1);
      return clamp32(pick(lo - 3, hi + 3) * (longint'(1) <<< FRAC_BITS_DEF) + frac);
   endfunction

   function automatic seg_box_cmd_type random_cmd();
      seg_box_cmd_type c;
      int              kind;
      longint          ax, ay, xl, xr, yb, yt, midx, midy;
      box_type         swap;
      kind = $urandom_range(0, 11);
      ax   = ($urandom_range(0, 3) == 0) ? pick(BOX_MIN, BOX_MAX) : pick(-40, 40);
      ay   = ($urandom_range(0, 3) == 0) ? pick(BOX_MIN, BOX_MAX) : pick(-40, 40);
      c.box_left   = clamp16(ax - center_x_model);
      c.box_right  = clamp16(ax - center_x_model + pick(0, 6));
      c.box_bottom = clamp16(ay - center_y_model);
      c.box_top    = clamp16(ay - center_y_model + pick(0, 6));
      xl = longint'(c.box_left) + center_x_model;
      xr = longint'(c.box_right) + center_x_model;
      yb = longint'(c.box_bottom) + center_y_model;
      yt = longint'(c.box_top) + center_y_model;
      c.seg_x0 = near_coord(xl, xr);
      c.seg_y0 = near_coord(yb, yt);
      c.seg_x1 = near_coord(xl, xr);
      c.seg_y1 = near_coord(yb, yt);
      case (kind)
         0: begin
            c = make_cmd($urandom, $urandom, $urandom, $urandom,
                         box_type'($urandom_range(0, 65535)),
                         box_type'($urandom_range(0, 65535)),
                         box_type'($urandom_range(0, 65535)),
                         box_type'($urandom_range(0, 65535)));
         end
         1: c.seg_x1 = c.seg_x0;
         2: begin
            c.seg_x1 = c.seg_x0;
            c.seg_y1 = c.seg_y0;
         end
         3: begin
            if ($urandom_range(0, 1)) begin
               swap        = c.box_left;
               c.box_left  = clamp16(longint'(c.box_right) + pick(1, 4));
               c.box_right = swap;
            end else begin
               swap         = c.box_bottom;
               c.box_bottom = clamp16(longint'(c.box_top) + pick(1, 4));
               c.box_top    = swap;
            end
         end
         4, 5: begin
            // long segment, small box near its midpoint
            c.seg_x0 = $urandom;
            c.seg_y0 = $urandom;
            c.seg_x1 = $urandom;
            c.seg_y1 = $urandom;
            midx = ((longint'(c.seg_x0) + c.seg_x1) >>> 1) >>> FRAC_BITS_DEF;
            midy = ((longint'(c.seg_y0) + c.seg_y1) >>> 1) >>> FRAC_BITS_DEF;
            c.box_left   = clamp16(midx - center_x_model - pick(0, 1));
            c.box_right  = clamp16(midx - center_x_model + pick(0, 1));
            c.box_bottom = clamp16(midy - center_y_model - pick(0, 2));
            c.box_top    = clamp16(midy - center_y_model + pick(0, 2));
         end
         6: c.seg_y1 = c.seg_y0;
         default: ;
      endcase
      return c;
   endfunction

   // ---- tests --------------------------------------------------------------
   task automatic test_directed_cases();
      // centers still at their reset value here
      send_cmd(make_cmd(-2*FX_ONE, -2*FX_ONE, 3*FX_ONE, 3*FX_ONE, 0, 0, 1, 1));
      send_cmd(make_cmd(3*FX_ONE, 3*FX_ONE, -2*FX_ONE, -2*FX_ONE, 0, 0, 1, 1));
      send_cmd(make_cmd(-2*FX_ONE, 5*FX_ONE, 3*FX_ONE, 5*FX_ONE, 0, 0, 1, 1));
      send_cmd(make_cmd(-2*FX_ONE, FX_ONE, 3*FX_ONE, FX_ONE, 0, 0, 1, 1));
      send_cmd(make_cmd(FX_HALF, -3*FX_ONE, FX_HALF, 3*FX_ONE, 0, 0, 1, 1));
      send_cmd(make_cmd(-FX_HALF, 3*FX_ONE, -FX_HALF, -3*FX_ONE, 0, 0, 1, 1));
      send_cmd(make_cmd(0, -3*FX_ONE, 0, 3*FX_ONE, 0, 0, 1, 1));
      send_cmd(make_cmd(-FX_LSB, -3*FX_ONE, -FX_LSB, 3*FX_ONE, 0, 0, 1, 1));
      // inverted rectangles
      send_cmd(make_cmd(-2*FX_ONE, -2*FX_ONE, 3*FX_ONE, 3*FX_ONE, 1, 0, 0, 1));
      send_cmd(make_cmd(-2*FX_ONE, -2*FX_ONE, 3*FX_ONE, 3*FX_ONE, 0, 1, 1, 0));
      // point segments: inside, on a corner, just outside
      send_cmd(make_cmd(FX_HALF, FX_HALF, FX_HALF, FX_HALF, 0, 0, 1, 1));
      send_cmd(make_cmd(FX_ONE, FX_ONE, FX_ONE, FX_ONE, 0, 0, 1, 1));
      send_cmd(make_cmd(FX_ONE + FX_LSB, FX_HALF, FX_ONE + FX_LSB, FX_HALF, 0, 0, 1, 1));
      // through a corner and one step past it
      send_cmd(make_cmd(2*FX_ONE, 0, 0, 2*FX_ONE, 0, 0, 1, 1));
      send_cmd(make_cmd(2*FX_ONE, FX_LSB, FX_LSB, 2*FX_ONE, 0, 0, 1, 1));
      send_cmd(make_cmd(0, 0, 3*FX_ONE, FX_ONE, 1, 0, 2, 0));
      // field extremes
      send_cmd(make_cmd(FX_MAX, FX_MIN, FX_MIN, FX_MAX, BOX_MIN, BOX_MIN, BOX_MAX, BOX_MAX));
      send_cmd(make_cmd(FX_MAX, FX_MAX, FX_MAX, FX_MAX, BOX_MAX, BOX_MAX, BOX_MAX, BOX_MAX));
      send_cmd(make_cmd(FX_MIN, FX_MIN, FX_MIN, FX_MIN, BOX_MIN, BOX_MIN, BOX_MIN, BOX_MIN));
      send_cmd(make_cmd(0, FX_MIN, FX_LSB, FX_MAX, 0, 0, 0, 0));
      send_cmd(make_cmd(FX_MIN, 0, FX_MAX, FX_LSB, 0, 0, 0, 0));
      send_cmd(make_cmd(32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555,
                        16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555));
      send_cmd(make_cmd(32'shaaaa_aaaa, 32'sh5555_5555, 32'sh5555_5555, 32'shaaaa_aaaa,
                        16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa));
   endtask

   task automatic test_center_extremes();
      set_centers(BOX_MAX, BOX_MIN);
      send_cmd(make_cmd(0, 0, FX_ONE, -FX_ONE, -32767, 32767, -32766, 32767));
      send_cmd(make_cmd(0, -5*FX_ONE, 3*FX_ONE, -2*FX_ONE, BOX_MIN, BOX_MIN, BOX_MAX, BOX_MAX));
      send_cmd(make_cmd(FX_MAX, FX_MAX, FX_MIN, FX_MIN, BOX_MIN, BOX_MIN, BOX_MAX, BOX_MAX));
      set_centers(BOX_MIN, BOX_MAX);
      send_cmd(make_cmd(-FX_ONE, -FX_ONE, -FX_ONE, -FX_ONE, BOX_MAX, BOX_MIN, BOX_MAX, BOX_MIN));
      send_cmd(make_cmd(FX_MIN, FX_MIN, FX_MAX, FX_MAX, BOX_MIN, BOX_MIN, BOX_MAX, BOX_MAX));
   endtask

   task automatic test_random_traffic();
      box_type cx, cy;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin cx = '0;      cy = '0;      end
            1: begin cx = BOX_MIN; cy = BOX_MIN; end
            2: begin cx = BOX_MAX; cy = BOX_MAX; end
            3: begin cx = box_type'(pick(-8, 8)); cy = box_type'(pick(-8, 8)); end
            default: begin
               cx = box_type'($urandom_range(0, 65535));
               cy = box_type'($urandom_range(0, 65535));
            end
         endcase
         set_centers(cx, cy);
         repeat (PHASE_CMDS) send_cmd(random_cmd());
      end
   endtask

   initial begin
      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_center_extremes();
      test_random_traffic();
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      $display("Checked %0d of %0d commands (%0d hits) over %0d center settings",
               results_checked, cmds_issued, hits_seen, center_settings);
      $display("with %0d register writes, spare indexes included", csr_writes);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sbit_pkg.sv
rtl/sbit_front.sv
rtl/sbit_mul.sv
rtl/sbit_judge.sv
rtl/segment_box_intersect_test_core.sv
rtl/sbit_checker.sv
tb/sv/tb.sv
